>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check helpers; define NO_ASSERTIONS to compile them away.
`ifndef NO_ASSERTIONS

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/sbad_pkg.sv
package sbad_pkg;

  localparam int unsigned AddrW    = 20;
  localparam int unsigned DataW    = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned SizeW    = 21;
  localparam int unsigned LimitW   = 17;
  localparam int unsigned DevNumW  = 3;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic ACTION_ACCESS = 1'b0;
  localparam logic ACTION_ATTACH = 1'b1;

  // register select on paddr[2]
  localparam logic REG_RAM_LIMIT = 1'b0;

  localparam logic [LimitW-1:0] RAM_LIMIT_RESET = 17'h10000;

  typedef enum logic [1:0] {
    KIND_MEM_READ  = 2'd0,
    KIND_MEM_WRITE = 2'd1,
    KIND_IO_READ   = 2'd2,
    KIND_IO_WRITE  = 2'd3
  } access_kind_e;

  typedef struct packed {
    logic [2:0]       pad;
    logic [SizeW-1:0] region_size;
    logic [AddrW-1:0] region_base;
    logic [ByteW-1:0] device_read_byte;
    logic [DataW-1:0] write_data;
    logic [AddrW-1:0] address;
  } in_data_t;

  typedef struct packed {
    access_kind_e access_kind;
    logic         action;
  } in_user_t;

  typedef struct packed {
    logic [4:0]         pad;
    logic               attach_taken;
    logic               out_of_range;
    logic [ByteW-1:0]   device_write_byte;
    logic               device_write_strobe;
    logic [AddrW-1:0]   offset_in_device;
    logic [DevNumW-1:0] device_number;
    logic               device_hit;
    logic [DataW-1:0]   bus_data;
  } result_t;

  typedef struct packed {
    logic latch;
    logic ram_rd;
    logic commit;
    logic rd_commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic attach;
    logic ram_read;
  } dp_status_t;

endpackage

>>> hdl/sbad_regs.sv
module sbad_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbad_pkg::CfgAddrW-1:0] paddr,
  input  logic [sbad_pkg::CfgDataW-1:0] pwdata,
  output logic [sbad_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output logic [sbad_pkg::LimitW-1:0]   ram_limit_o
);
  import sbad_pkg::*;

  logic [LimitW-1:0] ram_limit_q, ram_limit_d;
  logic              sel_limit;
  logic              wr_en;

  // word-aligned decode, low address bits ignored
  assign sel_limit = (paddr[CfgAddrW-1] == REG_RAM_LIMIT);
  assign wr_en     = psel && penable && pwrite && sel_limit;
  assign pready    = 1'b1;

  always_comb begin
    ram_limit_d = ram_limit_q;
    if (wr_en) begin
      ram_limit_d = pwdata[LimitW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_limit_q <= RAM_LIMIT_RESET;
    end else begin
      ram_limit_q <= ram_limit_d;
    end
  end

  assign prdata      = sel_limit ? CfgDataW'(ram_limit_q) : '0;
  assign ram_limit_o = ram_limit_q;

endmodule

>>> hdl/sbad_ctrl.sv
module sbad_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  input  sbad_pkg::dp_status_t   status_i,
  output sbad_pkg::ctrl_cmd_t    cmd_o
);
  import sbad_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MATCH  = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_READ   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       m_valid_q, m_valid_d;
  logic       out_free;
  ctrl_cmd_t  cmd;

  // output word slot is free if empty or being drained this cycle
  assign out_free = !m_valid_q || m_ready_i;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd.latch = 1'b1;
          state_d   = S_MATCH;
        end
      end
      S_MATCH: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (status_i.ram_read) begin
          cmd.ram_rd = 1'b1;
          state_d    = S_READ;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd.rd_commit = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit || cmd.rd_commit) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;
  assign cmd_o     = cmd;

endmodule

>>> hdl/sbad_datapath.sv
module sbad_datapath #(
  parameter int unsigned MAX_DEVICES = 8,
  parameter int unsigned RAM_BYTES   = 65536
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sbad_pkg::ctrl_cmd_t         cmd_i,
  output sbad_pkg::dp_status_t        status_o,
  input  sbad_pkg::in_data_t          in_data_i,
  input  sbad_pkg::in_user_t          in_user_i,
  input  logic [sbad_pkg::LimitW-1:0] ram_limit_i,
  output sbad_pkg::result_t           result_o
);
  import sbad_pkg::*;

  localparam int unsigned IdxW       = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int unsigned CntW       = $clog2(MAX_DEVICES + 1);
  localparam int unsigned EvenDepth  = (RAM_BYTES + 1) / 2;
  localparam int unsigned OddDepth   = RAM_BYTES / 2;
  localparam int unsigned EvenW      = (EvenDepth > 1) ? $clog2(EvenDepth) : 1;
  localparam int unsigned OddW       = (OddDepth > 1) ? $clog2(OddDepth) : 1;
  localparam logic [SizeW-1:0] RamBytesW = SizeW'(RAM_BYTES);
  localparam int unsigned SumW       = SizeW + 1;

  // latched item
  in_data_t item_q;
  in_user_t user_q;

  // device window table and bus state
  logic [AddrW-1:0]       base_q [MAX_DEVICES];
  logic [SizeW-1:0]       len_q  [MAX_DEVICES];
  logic [CntW-1:0]        count_q;
  logic [DataW-1:0]       held_q, held_d;
  logic [MAX_DEVICES-1:0] match_q, match_d;
  result_t                result_q, result_d;

  // byte banks
  logic [ByteW-1:0] even_mem [EvenDepth];
  logic [ByteW-1:0] odd_mem  [OddDepth];
  logic [ByteW-1:0] even_rd_q, odd_rd_q;

  logic [SumW-1:0]  addr_ext;
  logic             hit;
  logic [IdxW-1:0]  hit_idx;
  logic [AddrW-1:0] offset;
  logic [SizeW-1:0] addr21, lim, even_addr, odd_addr;
  logic             in_range, two;
  logic             is_write, is_attach, table_room;
  logic             ram_wr, even_used, odd_used;
  logic             even_we, odd_we, even_re, odd_re;
  logic [ByteW-1:0] even_wd, odd_wd, lo_byte, hi_byte;
  logic [DataW-1:0] rd_word, held_acc;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_data_i;
      user_q <= in_user_i;
    end
  end

  // window compare, one comparator per entry, registered
  assign addr_ext = SumW'(item_q.address);

  always_comb begin
    for (int i = 0; i < MAX_DEVICES; i++) begin
      match_d[i] = (CntW'(i) < count_q)
                && (addr_ext >= SumW'(base_q[i]))
                && (addr_ext < (SumW'(base_q[i]) + SumW'(len_q[i])));
    end
  end

  always_ff @(posedge clk_i) begin
    match_q <= match_d;
  end

  // first matching window wins
  always_comb begin
    hit_idx = '0;
    for (int i = MAX_DEVICES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx = IdxW'(i);
      end
    end
  end

  assign hit    = |match_q;
  assign offset = item_q.address - base_q[hit_idx];

  assign addr21   = SizeW'(item_q.address);
  assign lim      = (SizeW'(ram_limit_i) < RamBytesW) ? SizeW'(ram_limit_i) : RamBytesW;
  assign in_range = addr21 < lim;
  assign two      = (addr21 + SizeW'(1)) < lim;

  assign is_attach  = (user_q.action == ACTION_ATTACH);
  assign is_write   = (user_q.access_kind == KIND_MEM_WRITE)
                   || (user_q.access_kind == KIND_IO_WRITE);
  assign table_room = count_q < CntW'(MAX_DEVICES);

  assign status_o.attach   = is_attach;
  assign status_o.ram_read = !is_attach && !hit && in_range
                          && (user_q.access_kind == KIND_MEM_READ);

  // byte at address and address+1 always land in opposite banks
  assign even_addr = addr21 + SizeW'(item_q.address[0]);
  assign odd_addr  = addr21 + SizeW'(!item_q.address[0]);
  assign even_used = !item_q.address[0] || two;
  assign odd_used  = item_q.address[0] || two;

  assign ram_wr  = cmd_i.commit && !is_attach && !hit && in_range
                && (user_q.access_kind == KIND_MEM_WRITE);
  assign even_we = ram_wr && even_used;
  assign odd_we  = ram_wr && odd_used;
  assign even_re = cmd_i.ram_rd && even_used;
  assign odd_re  = cmd_i.ram_rd && odd_used;
  assign even_wd = item_q.address[0] ? item_q.write_data[15:8] : item_q.write_data[7:0];
  assign odd_wd  = item_q.address[0] ? item_q.write_data[7:0] : item_q.write_data[15:8];

  always_ff @(posedge clk_i) begin
    if (even_we) begin
      even_mem[even_addr[EvenW:1]] <= even_wd;
    end
    if (even_re) begin
      even_rd_q <= even_mem[even_addr[EvenW:1]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (odd_we) begin
      odd_mem[odd_addr[OddW:1]] <= odd_wd;
    end
    if (odd_re) begin
      odd_rd_q <= odd_mem[odd_addr[OddW:1]];
    end
  end

  assign lo_byte = item_q.address[0] ? odd_rd_q : even_rd_q;
  assign hi_byte = item_q.address[0] ? even_rd_q : odd_rd_q;
  assign rd_word = {two ? hi_byte : 8'h00, lo_byte};

  // bus value for an access that is not a RAM read
  always_comb begin
    held_acc = is_write ? item_q.write_data : held_q;
    if (hit && !is_write) begin
      held_acc = DataW'(item_q.device_read_byte);
    end
  end

  always_comb begin
    result_d = result_q;
    held_d   = held_q;
    if (cmd_i.commit) begin
      result_d = '0;
      if (is_attach) begin
        result_d.bus_data     = held_q;
        result_d.attach_taken = table_room;
      end else begin
        held_d                       = held_acc;
        result_d.bus_data            = held_acc;
        result_d.device_hit          = hit;
        result_d.device_number       = hit ? DevNumW'(hit_idx) : '0;
        result_d.offset_in_device    = hit ? offset : '0;
        result_d.device_write_strobe = hit && is_write;
        result_d.device_write_byte   = (hit && is_write) ? item_q.write_data[7:0] : '0;
        result_d.out_of_range        = !hit && !in_range;
      end
    end else if (cmd_i.rd_commit) begin
      result_d          = '0;
      result_d.bus_data = rd_word;
      held_d            = rd_word;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    if (cmd_i.commit && is_attach && table_room) begin
      base_q[count_q[IdxW-1:0]] <= item_q.region_base;
      len_q[count_q[IdxW-1:0]]  <= item_q.region_size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      held_q  <= '0;
    end else begin
      held_q <= held_d;
      if (cmd_i.commit && is_attach && table_room) begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  assign result_o = result_q;

endmodule

>>> hdl/system_bus_address_decoder.sv
// System bus address decoder.
// Input stream (s_axis): one word per bus access or window attach; tuser
// says which and carries the access kind. Output stream (m_axis): exactly
// one result word per input word, in order.
// An attach word appends a (base, size) window to the device table; once
// MAX_DEVICES windows are stored further attaches are dropped. An access
// word is decoded against the windows in parallel (first match wins);
// unmatched in-range memory accesses go to a byte RAM split into even/odd
// banks so a 16-bit word is read or written in a single access.
// Each word passes accept, registered window compare and resolve steps; a
// RAM read adds a read step as the bank read data is registered. One word
// is in flight at a time; s_axis_tready_o is high only when the decoder is
// idle. The result sits in an output register: a stalled receiver holds
// the word there and the decoder waits in its resolve step, or a RAM read
// in its read step, before committing. Reset empties the window table,
// clears the held data bus and the output valid, and sets ram_limit to
// 65536; RAM contents are not cleared. The user must write ram_limit over
// the APB port only while the decoder is idle; it does not enforce this.
`include "assert_macros.svh"

module system_bus_address_decoder #(
  parameter int unsigned MAX_DEVICES = 8,
  parameter int unsigned RAM_BYTES   = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // APB configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sbad_pkg::CfgAddrW-1:0]   paddr,
  input  logic [sbad_pkg::CfgDataW-1:0]   pwdata,
  output logic [sbad_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready,
  // input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // address, write_data, device_read_byte, region_base, region_size, pad
  input  logic [sbad_pkg::InDataW-1:0]    s_axis_tdata_i,
  // action, access_kind
  input  logic [sbad_pkg::InUserW-1:0]    s_axis_tuser_i,
  // output stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // bus_data, device_hit, device_number, offset_in_device,
  // device_write_strobe, device_write_byte, out_of_range, attach_taken, pad
  output logic [sbad_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import sbad_pkg::*;

  ctrl_cmd_t         cmd;
  dp_status_t        status;
  result_t           result;
  logic [LimitW-1:0] ram_limit;

  sbad_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .ram_limit_o (ram_limit)
  );

  sbad_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  sbad_datapath #(
    .MAX_DEVICES (MAX_DEVICES),
    .RAM_BYTES   (RAM_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_t'(s_axis_tdata_i)),
    .in_user_i   (in_user_t'(s_axis_tuser_i)),
    .ram_limit_i (ram_limit),
    .result_o    (result)
  );

  assign m_axis_tdata_o = result;

  `ASSERT_IMPL(a_commit_excl, clk_i, rst_ni, cmd.commit, !cmd.rd_commit)
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  `ASSERT_NEXT(a_read_pending, clk_i, rst_ni, cmd.ram_rd, !s_axis_tready_o)
  `ASSERT_IMPL(a_valid_source, clk_i, rst_ni, $rose(m_axis_tvalid_o), $past(cmd.commit || cmd.rd_commit))

endmodule
